// ===== rtl/core/sdra_pkg.sv =====
// shared types, constants and control program for the sort and ring area unit
`default_nettype none

package sdra_pkg;

    // field widths
    localparam int DIST_W = 15;
    localparam int AREA_W = 35;
    localparam int SUM_W  = 33;
    localparam int SQ_W   = 2 * DIST_W;

    // pi scale 3141592 / 1000000 as ceil(2^51 * 3.141592); the error stays
    // small enough that the integer bits of sum * RECIP give the exact floor
    // for every 33-bit sum
    localparam int RECIP_W  = 53;
    localparam int RECIP_SH = 51;
    localparam logic [RECIP_W-1:0] RECIP = 53'd7074236280275066;

    // product of sum and scale
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam int LC_W   = 6;

    localparam int NUM_VALUES_DEF = 64;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_ACC,
        OP_CMP,
        OP_PLACE,
        OP_MUL_INIT,
        OP_MUL_STEP,
        OP_OUT_INIT,
        OP_OUT
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_POS_ZERO,
        C_SHIFT_MORE,
        C_NOT_FULL,
        C_LOOP,
        C_OUT_MORE
    } cond_t;

    typedef logic [3:0] step_t;

    localparam step_t ST_WAIT     = 4'd0;
    localparam step_t ST_ACC      = 4'd1;
    localparam step_t ST_CMP      = 4'd2;
    localparam step_t ST_PLACE    = 4'd3;
    localparam step_t ST_MUL_INIT = 4'd4;
    localparam step_t ST_MUL      = 4'd5;
    localparam step_t ST_OUT_INIT = 4'd6;
    localparam step_t ST_OUT      = 4'd7;
    localparam step_t ST_JUMP     = 4'd8;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic stall;
        logic pos_zero;
        logic shift_more;
        logic not_full;
        logic loop_more;
        logic out_more;
    } flags_t;

    // control store
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t cw;
        unique case (step)
            ST_WAIT:     cw = '{OP_WAIT,     C_NEVER,      ST_ACC};
            ST_ACC:      cw = '{OP_ACC,      C_POS_ZERO,   ST_PLACE};
            ST_CMP:      cw = '{OP_CMP,      C_SHIFT_MORE, ST_CMP};
            ST_PLACE:    cw = '{OP_PLACE,    C_NOT_FULL,   ST_WAIT};
            ST_MUL_INIT: cw = '{OP_MUL_INIT, C_NEVER,      ST_MUL};
            ST_MUL:      cw = '{OP_MUL_STEP, C_LOOP,       ST_MUL};
            ST_OUT_INIT: cw = '{OP_OUT_INIT, C_NEVER,      ST_OUT};
            ST_OUT:      cw = '{OP_OUT,      C_OUT_MORE,   ST_OUT};
            ST_JUMP:     cw = '{OP_NOP,      C_ALWAYS,     ST_WAIT};
            default:     cw = '{OP_NOP,      C_ALWAYS,     ST_WAIT};
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sdra_seq.sv =====
// microcode sequencer: step counter, control store and jump logic
`default_nettype none

module sdra_seq (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire sdra_pkg::flags_t flags,
    output sdra_pkg::ctrl_t      ctrl
);
    import sdra_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  jump;

    assign ctrl = ucode(step_reg);

    always_comb begin
        unique case (ctrl.cond)
            C_NEVER:      jump = 1'b0;
            C_ALWAYS:     jump = 1'b1;
            C_POS_ZERO:   jump = flags.pos_zero;
            C_SHIFT_MORE: jump = flags.shift_more;
            C_NOT_FULL:   jump = flags.not_full;
            C_LOOP:       jump = flags.loop_more;
            C_OUT_MORE:   jump = flags.out_more;
            default:      jump = 1'b0;
        endcase
    end

    always_comb begin
        priority if (flags.stall) begin
            step_next = step_reg;
        end else if (jump) begin
            step_next = ctrl.target;
        end else begin
            step_next = step_reg + step_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sdra_dp.sv =====
// datapath: value store, insertion shift, square sum, serial reciprocal multiply, result register
`default_nettype none

module sdra_dp #(
    parameter int NUM_VALUES = sdra_pkg::NUM_VALUES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire sdra_pkg::ctrl_t                   ctrl,
    output sdra_pkg::flags_t                       flags,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [sdra_pkg::DIST_W-1:0] s_distance,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [sdra_pkg::DIST_W-1:0]     m_sorted_value,
    output logic [sdra_pkg::AREA_W-1:0]            m_ring_area,
    output logic                                   m_last_of_run
);
    import sdra_pkg::*;

    localparam int AW = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_VALUES - 1);

    // value store
    logic signed [DIST_W-1:0] mem [NUM_VALUES];
    logic signed [DIST_W-1:0] rd_data_reg;

    logic signed [DIST_W-1:0] key_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [AW-1:0]            pos_reg;
    logic [AW-1:0]            cnt_reg;
    logic [AW-1:0]            k_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [PROD_W-1:0]        acc_reg;
    logic [LC_W-1:0]          lc_reg;

    logic                     m_valid_reg;
    logic signed [DIST_W-1:0] m_sorted_value_reg;
    logic [AREA_W-1:0]        m_ring_area_reg;
    logic                     m_last_of_run_reg;

    logic                     in_xfer;
    logic                     out_busy;
    logic                     out_load;
    logic                     gt;
    logic signed [DIST_W:0]   d_ext;
    logic signed [DIST_W:0]   mag_full;
    logic [DIST_W-1:0]        mag;
    logic [SQ_W-1:0]          sq_next;
    logic [SUM_W:0]           sum_add;
    logic [SUM_W-1:0]         sum_next;
    logic [LC_W-1:0]          mul_bit;
    logic [SUM_W:0]           mul_hi;
    logic [PROD_W-1:0]        mul_next;

    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [DIST_W-1:0] wr_data;

    assign s_ready  = (ctrl.op == OP_WAIT);
    assign in_xfer  = s_valid & s_ready;
    assign out_busy = m_valid_reg & ~m_ready;
    assign out_load = (ctrl.op == OP_OUT) & ~out_busy;
    assign gt       = rd_data_reg > key_reg;

    // magnitude and square of the incoming value
    assign d_ext    = {s_distance[DIST_W-1], s_distance};
    assign mag_full = d_ext[DIST_W] ? -d_ext : d_ext;
    assign mag      = mag_full[DIST_W-1:0];
    assign sq_next  = SQ_W'(mag) * SQ_W'(mag);

    // saturating square sum
    assign sum_add  = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);
    assign sum_next = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

    // shift-add multiply by the pi scale, lsb first, product shifts right
    assign mul_bit  = LC_W'(RECIP_W - 1) - lc_reg;
    assign mul_hi   = {1'b0, acc_reg[PROD_W-1:RECIP_W]}
                    + (RECIP[mul_bit] ? {1'b0, sum_reg} : (SUM_W + 1)'(0));
    assign mul_next = {mul_hi, acc_reg[RECIP_W-1:1]};

    // store port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = pos_reg - AW'(1);
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = key_reg;
        unique case (ctrl.op)
            OP_ACC: begin
                rd_en = (pos_reg != '0);
            end
            OP_CMP: begin
                rd_en   = flags.shift_more;
                rd_addr = pos_reg - AW'(2);
                wr_en   = gt;
                wr_data = rd_data_reg;
            end
            OP_PLACE: begin
                wr_en = 1'b1;
            end
            OP_OUT_INIT: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            OP_OUT: begin
                rd_en   = out_load & flags.out_more;
                rd_addr = k_reg + AW'(1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        flags.stall      = ((ctrl.op == OP_WAIT) & ~s_valid)
                         | ((ctrl.op == OP_OUT) & out_busy);
        flags.pos_zero   = (pos_reg == '0);
        flags.shift_more = gt & (pos_reg > AW'(1));
        flags.not_full   = (cnt_reg != LAST_IDX);
        flags.loop_more  = (lc_reg != '0);
        flags.out_more   = (k_reg != LAST_IDX);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            cnt_reg     <= '0;
            k_reg       <= '0;
            sum_reg     <= '0;
            lc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (ctrl.op)
                OP_WAIT: begin
                    if (in_xfer) begin
                        pos_reg <= cnt_reg;
                    end
                end
                OP_ACC: begin
                    sum_reg <= sum_next;
                end
                OP_CMP: begin
                    if (gt) begin
                        pos_reg <= pos_reg - AW'(1);
                    end
                end
                OP_PLACE: begin
                    cnt_reg <= (cnt_reg == LAST_IDX) ? '0 : cnt_reg + AW'(1);
                end
                OP_MUL_INIT: begin
                    lc_reg <= LC_W'(RECIP_W - 1);
                end
                OP_MUL_STEP: begin
                    lc_reg <= lc_reg - LC_W'(1);
                end
                OP_OUT_INIT: begin
                    k_reg   <= '0;
                    sum_reg <= '0;
                end
                OP_OUT: begin
                    if (out_load) begin
                        k_reg <= k_reg + AW'(1);
                    end
                end
                default: begin
                end
            endcase

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            key_reg <= s_distance;
            sq_reg  <= sq_next;
        end
        unique case (ctrl.op)
            OP_MUL_INIT: acc_reg <= '0;
            OP_MUL_STEP: acc_reg <= mul_next;
            default: begin
            end
        endcase
        if (out_load) begin
            m_sorted_value_reg <= rd_data_reg;
            m_last_of_run_reg  <= (k_reg == LAST_IDX);
            m_ring_area_reg    <= (k_reg == LAST_IDX) ? acc_reg[RECIP_SH +: AREA_W] : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sorted_value = m_sorted_value_reg;
    assign m_ring_area    = m_ring_area_reg;
    assign m_last_of_run  = m_last_of_run_reg;

    // results leave in ascending order within a run
    a_sorted_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (k_reg != '0)) |-> (m_sorted_value_reg <= rd_data_reg))
        else $error("sorted results out of order");

    // the shift never reads the entry it overwrites
    a_port_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("store read and write at the same entry");

    // a waiting result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_sorted_value_reg)
            && $stable(m_ring_area_reg) && $stable(m_last_of_run_reg)))
        else $error("result changed while waiting");

    // square sum never falls while accumulating
    a_sum_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_ACC) |=> (sum_reg >= $past(sum_reg)))
        else $error("square sum decreased");

endmodule

`default_nettype wire

// ===== rtl/core/sort_distances_ring_area_unit.sv =====
// top level of the sort and ring area unit
`default_nettype none

// Collects NUM_VALUES signed 15-bit distances, one per input transfer, and keeps
// them in ascending order by inserting each new value into a one-port-read,
// one-port-write store as it arrives (equal values keep arrival order). No
// result leaves until the run is complete. Each value is accepted, its square
// added to the square sum, and then written in place; into a non-empty store
// a compare step first runs for each entry the insertion walk visits (every
// entry shifted up, and the entry that stops the walk if there is one). After
// the last value a serial shift-add multiplier scales the saturating 33-bit
// square sum by a 53-bit fixed-point form of 3141592 / 1000000 and keeps the
// integer bits, which is exactly the truncated ring area. A priming step reads
// the first store entry, then the NUM_VALUES sorted values are sent in order,
// one per cycle while the sink is ready, with the ring area and last_of_run
// set on the final transfer only (ring area reads zero on the others); a
// jump step then returns to loading. A new run may begin loading while the
// final result still waits in the output register. Control comes from a small
// microcode store stepped by a sequencer; the datapath has no other state
// machine. Reset clears counters and the square sum; the store needs no
// clearing because every entry of a run is written before it is read.

module sort_distances_ring_area_unit #(
    parameter int NUM_VALUES = sdra_pkg::NUM_VALUES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [sdra_pkg::DIST_W-1:0] s_distance,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [sdra_pkg::DIST_W-1:0]     m_sorted_value,
    output logic [sdra_pkg::AREA_W-1:0]            m_ring_area,
    output logic                                   m_last_of_run
);
    import sdra_pkg::*;

    // control word for the current step and datapath status for jumps
    ctrl_t  ctrl;
    flags_t flags;

    sdra_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    sdra_dp #(
        .NUM_VALUES (NUM_VALUES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .flags          (flags),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_distance     (s_distance),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_ring_area    (m_ring_area),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

`default_nettype wire
